/* design/tss_pkg.sv */
// ----------------------------------------------------------------------------
// tss_pkg
// Shared widths, codes and command types for the three stack block.
// ----------------------------------------------------------------------------
package tss_pkg;

  // memory geometry
  localparam int MEM_DEPTH = 1024;
  localparam int ADDR_W    = $clog2(MEM_DEPTH);
  localparam int DATA_W    = 32;

  // field widths
  localparam int SIZE_W = 11;
  localparam int CNT_W  = 11;
  localparam int SEL_W  = 2;
  localparam int STAT_W = 2;
  localparam int VAL_W  = 32;
  localparam int CFG_W  = 2;

  // address arithmetic width: holds base + count and the memory depth
  localparam int SUM_W = SIZE_W + 2;
  localparam int CMP_W = (ADDR_W + 1 > SUM_W) ? ADDR_W + 1 : SUM_W;

  // operation codes
  localparam logic MODE_PUSH = 1'b0;
  localparam logic MODE_POP  = 1'b1;

  // stack selectors
  localparam logic [SEL_W-1:0] SEL_FIRST  = 2'd0;
  localparam logic [SEL_W-1:0] SEL_SECOND = 2'd1;
  localparam logic [SEL_W-1:0] SEL_THIRD  = 2'd2;

  // result status codes
  localparam logic [STAT_W-1:0] ST_DONE  = 2'd0;
  localparam logic [STAT_W-1:0] ST_FULL  = 2'd1;
  localparam logic [STAT_W-1:0] ST_EMPTY = 2'd2;

  // configuration register indexes
  localparam logic [CFG_W-1:0] CFG_FIRST_SIZE  = 2'd0;
  localparam logic [CFG_W-1:0] CFG_SECOND_SIZE = 2'd1;
  localparam logic [CFG_W-1:0] CFG_THIRD_SIZE  = 2'd2;

  // commands from controller to datapath
  typedef struct packed {
    logic capture;
    logic exec;
    logic load;
  } tss_cmd_t;

endpackage

/* design/tss_ctrl.sv */
// ----------------------------------------------------------------------------
// tss_ctrl
// Sequencer: takes an item, runs it through the memory, loads the result.
// ----------------------------------------------------------------------------
module tss_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  output logic              in_tready,
  output logic              out_tvalid,
  input  logic              out_tready,
  output tss_pkg::tss_cmd_t cmd
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_LOAD
  } state_t;

  state_t state_r;
  logic   out_valid_r;
  logic   out_free;

  // output register can take a new result
  assign out_free = !out_valid_r || out_tready;

  // handshake and commands
  always_comb begin
    in_tready   = (state_r == S_IDLE);
    cmd.capture = in_tvalid && (state_r == S_IDLE);
    cmd.exec    = (state_r == S_EXEC);
    cmd.load    = (state_r == S_LOAD) && out_free;
  end

  assign out_tvalid = out_valid_r;

  // state and output valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      unique case (state_r)
        S_IDLE: begin
          if (in_tvalid) state_r <= S_EXEC;
        end
        S_EXEC: begin
          state_r <= S_LOAD;
        end
        S_LOAD: begin
          if (out_free) state_r <= S_IDLE;
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
      if (cmd.load) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

endmodule

/* design/tss_datapath.sv */
// ----------------------------------------------------------------------------
// tss_datapath
// Size and count registers, address arithmetic, shared memory, result register.
// ----------------------------------------------------------------------------
module tss_datapath (
  input  logic                          clk,
  input  logic                          rst_n,
  input  tss_pkg::tss_cmd_t             cmd,
  input  logic                          cfg_we,
  input  logic [tss_pkg::CFG_W-1:0]     cfg_addr,
  input  logic [tss_pkg::SIZE_W-1:0]    cfg_wdata,
  input  logic                          in_mode,
  input  logic [tss_pkg::SEL_W-1:0]     in_sel,
  input  logic [tss_pkg::VAL_W-1:0]     in_value,
  output logic [tss_pkg::STAT_W-1:0]    out_status,
  output logic [tss_pkg::VAL_W-1:0]     out_value
);

  // shared memory
  logic [tss_pkg::DATA_W-1:0] mem [tss_pkg::MEM_DEPTH];

  // configuration and stack state
  logic [tss_pkg::SIZE_W-1:0] first_size_r, second_size_r, third_size_r;
  logic [tss_pkg::CNT_W-1:0]  first_cnt_r, second_cnt_r, third_cnt_r;
  logic [tss_pkg::CNT_W-1:0]  first_cnt_nxt, second_cnt_nxt, third_cnt_nxt;

  // captured item
  logic                       mode_r;
  logic [tss_pkg::SEL_W-1:0]  sel_r;
  logic [tss_pkg::VAL_W-1:0]  value_r;

  // execute results
  logic [tss_pkg::STAT_W-1:0] stat_r;
  logic                       pop_ok_r;
  logic [tss_pkg::DATA_W-1:0] rdata_r;
  logic [tss_pkg::STAT_W-1:0] out_status_r;
  logic [tss_pkg::VAL_W-1:0]  out_value_r;

  // selected stack view
  logic                       sel_ok;
  logic [tss_pkg::CNT_W-1:0]  cnt;
  logic [tss_pkg::SIZE_W-1:0] size;
  logic [tss_pkg::CMP_W-1:0]  base;
  logic [tss_pkg::CMP_W-1:0]  push_addr;
  logic [tss_pkg::CMP_W-1:0]  pop_addr;
  logic                       push_full;
  logic                       wr_en;
  logic                       rd_en;
  logic [tss_pkg::CNT_W-1:0]  cnt_upd;
  logic                       cnt_we;
  logic [tss_pkg::STAT_W-1:0] stat_nxt;

  // pick the selected stack's count, size and base
  always_comb begin
    sel_ok = 1'b1;
    cnt    = '0;
    size   = '0;
    base   = '0;
    unique case (sel_r)
      tss_pkg::SEL_FIRST: begin
        cnt  = first_cnt_r;
        size = first_size_r;
      end
      tss_pkg::SEL_SECOND: begin
        cnt  = second_cnt_r;
        size = second_size_r;
        base = tss_pkg::CMP_W'(first_size_r);
      end
      tss_pkg::SEL_THIRD: begin
        cnt  = third_cnt_r;
        size = third_size_r;
        base = tss_pkg::CMP_W'(first_size_r) + tss_pkg::CMP_W'(second_size_r);
      end
      default: begin
        sel_ok = 1'b0;
      end
    endcase
  end

  // slot addresses and the full check
  assign push_addr = base + tss_pkg::CMP_W'(cnt);
  assign pop_addr  = push_addr - tss_pkg::CMP_W'(1);
  assign push_full = (cnt >= size) || (push_addr >= tss_pkg::CMP_W'(tss_pkg::MEM_DEPTH));

  // operation decode
  always_comb begin
    stat_nxt = tss_pkg::ST_DONE;
    wr_en    = 1'b0;
    rd_en    = 1'b0;
    cnt_we   = 1'b0;
    cnt_upd  = cnt;
    if (sel_ok) begin
      if (mode_r == tss_pkg::MODE_PUSH) begin
        if (push_full) begin
          stat_nxt = tss_pkg::ST_FULL;
        end else begin
          wr_en   = 1'b1;
          cnt_we  = 1'b1;
          cnt_upd = cnt + tss_pkg::CNT_W'(1);
        end
      end else begin
        if (cnt == '0) begin
          stat_nxt = tss_pkg::ST_EMPTY;
        end else begin
          cnt_we  = 1'b1;
          cnt_upd = cnt - tss_pkg::CNT_W'(1);
          rd_en   = (pop_addr < tss_pkg::CMP_W'(tss_pkg::MEM_DEPTH));
        end
      end
    end
  end

  // count next values
  always_comb begin
    first_cnt_nxt  = first_cnt_r;
    second_cnt_nxt = second_cnt_r;
    third_cnt_nxt  = third_cnt_r;
    if (cmd.exec && cnt_we) begin
      unique case (sel_r)
        tss_pkg::SEL_FIRST:  first_cnt_nxt  = cnt_upd;
        tss_pkg::SEL_SECOND: second_cnt_nxt = cnt_upd;
        tss_pkg::SEL_THIRD:  third_cnt_nxt  = cnt_upd;
        default: ;
      endcase
    end
  end

  // control state: sizes and counts
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      first_size_r  <= '0;
      second_size_r <= '0;
      third_size_r  <= '0;
      first_cnt_r   <= '0;
      second_cnt_r  <= '0;
      third_cnt_r   <= '0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_addr)
          tss_pkg::CFG_FIRST_SIZE:  first_size_r  <= cfg_wdata;
          tss_pkg::CFG_SECOND_SIZE: second_size_r <= cfg_wdata;
          tss_pkg::CFG_THIRD_SIZE:  third_size_r  <= cfg_wdata;
          default: ;
        endcase
      end
      first_cnt_r  <= first_cnt_nxt;
      second_cnt_r <= second_cnt_nxt;
      third_cnt_r  <= third_cnt_nxt;
    end
  end

  // item capture, execute-stage payload and result register
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      mode_r  <= in_mode;
      sel_r   <= in_sel;
      value_r <= in_value;
    end
    if (cmd.exec) begin
      stat_r   <= stat_nxt;
      pop_ok_r <= rd_en;
    end
    if (cmd.load) begin
      out_status_r <= stat_r;
      out_value_r  <= pop_ok_r ? tss_pkg::VAL_W'(rdata_r) : '0;
    end
  end

  // single port memory with registered read
  always_ff @(posedge clk) begin
    if (cmd.exec && wr_en) begin
      mem[push_addr[tss_pkg::ADDR_W-1:0]] <= tss_pkg::DATA_W'(value_r);
    end
    if (cmd.exec && rd_en) begin
      rdata_r <= mem[pop_addr[tss_pkg::ADDR_W-1:0]];
    end
  end

  assign out_status = out_status_r;
  assign out_value  = out_value_r;

endmodule

/* design/three_stacks_shared_memory.sv */
// A result is registered on the output after its input is captured, executed
// and loaded. The sequencer takes no new item until the last one is loaded; it
// steps through capture, execute and load for each item, and a result that is
// not taken holds the sequencer, and so the next item, in its load step.
// Reset (rst_n low at a clock edge) clears the sizes, the three counts, the
// sequencer and the output valid; memory contents are not cleared.
// ----------------------------------------------------------------------------
// three_stacks_shared_memory
// Three LIFO stacks in consecutive regions of one shared memory.
// ----------------------------------------------------------------------------
module three_stacks_shared_memory (
  input  logic                        clk,
  input  logic                        rst_n,
  // configuration write port
  input  logic                        cfg_we,
  input  logic [tss_pkg::CFG_W-1:0]   cfg_addr,
  input  logic [tss_pkg::SIZE_W-1:0]  cfg_wdata,
  // input stream
  input  logic                        in_tvalid,
  output logic                        in_tready,
  input  logic [31:0]                 in_tdata,   // [31:0] push_value
  input  logic [2:0]                  in_tuser,   // [0] mode, [2:1] stack_select
  // result stream
  output logic                        out_tvalid,
  input  logic                        out_tready,
  output logic [31:0]                 out_tdata,  // [31:0] pop_value
  output logic [1:0]                  out_tuser   // [1:0] status
);

  tss_pkg::tss_cmd_t cmd;

  // sequencer
  tss_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .cmd        (cmd)
  );

  // stack state, memory and result register
  tss_datapath u_datapath (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata),
    .in_mode    (in_tuser[0]),
    .in_sel     (in_tuser[2:1]),
    .in_value   (in_tdata),
    .out_status (out_tuser),
    .out_value  (out_tdata)
  );

endmodule
